[rtl/assert_macros.svh]
// Assertion macros for the RTL of the point to segment distance block.
// No dependencies; each macro compiles to nothing when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Implication: when cond holds, prop holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop)
`endif
`endif

[rtl/psd_pkg.sv]
// Package for the point to segment distance block: widths, register indexes, part codes.
// No dependencies.
package psd_pkg;

  localparam int COORD_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int RAD_W       = SUM_W + 1;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STAGES = RAD_W / 2;
  localparam int NUM_W       = PROD_W;
  localparam int QUO_W       = NUM_W - ROOT_W;
  localparam int DIV_STAGES  = QUO_W;
  localparam int DIR_W       = FRAC_BITS + 2;
  localparam int PART_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 2'd3;

  localparam logic [PART_W-1:0] PART_START = 2'd0;
  localparam logic [PART_W-1:0] PART_INNER = 2'd1;
  localparam logic [PART_W-1:0] PART_END   = 2'd2;

  function automatic logic [DIFF_W-1:0] mag_diff(input logic [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(~v + 1'b1) : v;
  endfunction

endpackage

[rtl/psd_sqrt.sv]
// Pipelined integer square root, one root bit per stage (floor of the root).
// Depends on psd_pkg.
module psd_sqrt import psd_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  sub;
    logic              ge;

    if (k == 0) begin : g_head
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_body
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign trial = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign sub   = {2'b00, root_in, 2'b01};
    assign ge    = trial >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        rem_q[k]  <= ge ? REM_W'(trial - sub) : trial[REM_W-1:0];
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

[rtl/psd_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on psd_pkg; expects num_i < den_i * 2^QUO_W.
module psd_div import psd_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic [QUO_W-1:0]  quo_o
);

  logic [QUO_W-1:0]  low_q [DIV_STAGES];
  logic [ROOT_W-1:0] rem_q [DIV_STAGES];
  logic [ROOT_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0]  quo_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [QUO_W-1:0]  low_in;
    logic [ROOT_W-1:0] rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [ROOT_W:0]   trial;
    logic              ge;

    if (k == 0) begin : g_head
      assign low_in = num_i[QUO_W-1:0];
      assign rem_in = num_i[NUM_W-1 -: ROOT_W];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_body
      assign low_in = low_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        low_q[k] <= {low_in[QUO_W-2:0], 1'b0};
        rem_q[k] <= ge ? ROOT_W'(trial - {1'b0, den_in}) : trial[ROOT_W-1:0];
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

[rtl/point_segment_distance.sv]
// Point to segment distance: an item passes from input accept to output valid through
// 6 front stages, 34 square root stages, 32 divider stages and 1 output register.
// Throughput one item per cycle; the whole pipeline holds while the output is stalled.
// Reset clears all valid bits and the endpoint registers to zero.
// Depends on psd_pkg, psd_sqrt, psd_div and assert_macros.svh.
`include "assert_macros.svh"

module point_segment_distance import psd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [COORD_W-1:0]         cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [COORD_W-1:0]  point_x_i,
  input  logic signed [COORD_W-1:0]  point_y_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [COORD_W-1:0]         distance_o,
  output logic signed [DIR_W-1:0]   dir_x_o,
  output logic signed [DIR_W-1:0]   dir_y_o,
  output logic [PART_W-1:0]          nearest_part_o
);

  typedef struct packed {
    logic [PART_W-1:0] part;
    logic              dir_off;
    logic              zero_all;
    logic              vx_neg;
    logic              vy_neg;
    logic [DIFF_W-1:0] vx_mag;
    logic [DIFF_W-1:0] vy_mag;
    logic [NUM_W-1:0]  cross_mag;
  } sba_t;

  typedef struct packed {
    logic [PART_W-1:0] part;
    logic              dir_off;
    logic              zero_all;
    logic              vx_neg;
    logic              vy_neg;
    logic              sat;
    logic [ROOT_W-1:0] root;
  } sbb_t;

  logic signed [COORD_W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic en;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_X: start_x_q <= cfg_data_i;
        REG_START_Y: start_y_q <= cfg_data_i;
        REG_END_X:   end_x_q   <= cfg_data_i;
        REG_END_Y:   end_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits
  logic                   v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [SQRT_STAGES-1:0] vsq_q;
  logic [DIV_STAGES-1:0]  vdv_q;
  logic                   vout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      vsq_q  <= '0;
      vdv_q  <= '0;
      vout_q <= 1'b0;
    end else if (en) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      vsq_q  <= {vsq_q[SQRT_STAGES-2:0], v6_q};
      vdv_q  <= {vdv_q[DIV_STAGES-2:0], vsq_q[SQRT_STAGES-1]};
      vout_q <= vdv_q[DIV_STAGES-1];
    end
  end

  assign out_valid_o = vout_q;

  // stage 1: differences
  logic signed [DIFF_W-1:0] ux1_q, uy1_q, dx1_q, dy1_q, wx1_q, wy1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux1_q <= DIFF_W'(point_x_i) - DIFF_W'(start_x_q);
      uy1_q <= DIFF_W'(point_y_i) - DIFF_W'(start_y_q);
      dx1_q <= DIFF_W'(end_x_q)   - DIFF_W'(start_x_q);
      dy1_q <= DIFF_W'(end_y_q)   - DIFF_W'(start_y_q);
      wx1_q <= DIFF_W'(point_x_i) - DIFF_W'(end_x_q);
      wy1_q <= DIFF_W'(point_y_i) - DIFF_W'(end_y_q);
    end
  end

  // stage 2: products
  logic signed [DIFF_W-1:0] ux2_q, uy2_q, dx2_q, dy2_q, wx2_q, wy2_q;
  logic signed [PROD_W-1:0] dxx_q, dyy_q, udx_q, udy_q, cra_q, crb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxx_q <= dx1_q * dx1_q;
      dyy_q <= dy1_q * dy1_q;
      udx_q <= ux1_q * dx1_q;
      udy_q <= uy1_q * dy1_q;
      cra_q <= dx1_q * uy1_q;
      crb_q <= dy1_q * ux1_q;
      ux2_q <= ux1_q;
      uy2_q <= uy1_q;
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;
      wx2_q <= wx1_q;
      wy2_q <= wy1_q;
    end
  end

  // stage 3: length squared, dot and cross
  logic signed [DIFF_W-1:0] ux3_q, uy3_q, dx3_q, dy3_q, wx3_q, wy3_q;
  logic signed [SUM_W-1:0]  len2_3_q, dot3_q, cross3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      len2_3_q <= SUM_W'(dxx_q) + SUM_W'(dyy_q);
      dot3_q   <= SUM_W'(udx_q) + SUM_W'(udy_q);
      cross3_q <= SUM_W'(cra_q) - SUM_W'(crb_q);
      ux3_q    <= ux2_q;
      uy3_q    <= uy2_q;
      dx3_q    <= dx2_q;
      dy3_q    <= dy2_q;
      wx3_q    <= wx2_q;
      wy3_q    <= wy2_q;
    end
  end

  // stage 4: pick the nearest part and the vector to normalize
  logic                 zero_len, past_end, left;
  logic [PART_W-1:0]    part_d;
  logic                 vxn_d, vyn_d;
  logic [DIFF_W-1:0]    vxm_d, vym_d;
  logic [SUM_W-1:0]     cross_abs;
  sba_t                 sb4_q;
  logic [SUM_W-1:0]     len2_4_q;

  always_comb begin
    zero_len  = len2_3_q == '0;
    past_end  = dot3_q > len2_3_q;
    left      = !cross3_q[SUM_W-1];
    cross_abs = cross3_q[SUM_W-1] ? SUM_W'(-cross3_q) : SUM_W'(cross3_q);
    if (zero_len || dot3_q[SUM_W-1]) begin
      part_d = PART_START;
      vxn_d  = ux3_q[DIFF_W-1];
      vyn_d  = uy3_q[DIFF_W-1];
      vxm_d  = mag_diff(ux3_q);
      vym_d  = mag_diff(uy3_q);
    end else if (past_end) begin
      part_d = PART_END;
      vxn_d  = wx3_q[DIFF_W-1];
      vyn_d  = wy3_q[DIFF_W-1];
      vxm_d  = mag_diff(wx3_q);
      vym_d  = mag_diff(wy3_q);
    end else begin
      // normal toward the point side: left gives (-dy, dx), right (dy, -dx)
      part_d = PART_INNER;
      vxn_d  = left ? !dy3_q[DIFF_W-1] : dy3_q[DIFF_W-1];
      vyn_d  = left ? dx3_q[DIFF_W-1] : !dx3_q[DIFF_W-1];
      vxm_d  = mag_diff(dy3_q);
      vym_d  = mag_diff(dx3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb4_q.part      <= part_d;
      sb4_q.dir_off   <= zero_len;
      sb4_q.zero_all  <= (part_d == PART_INNER) && (cross3_q == '0);
      sb4_q.vx_neg    <= vxn_d;
      sb4_q.vy_neg    <= vyn_d;
      sb4_q.vx_mag    <= vxm_d;
      sb4_q.vy_mag    <= vym_d;
      sb4_q.cross_mag <= cross_abs[NUM_W-1:0];
      len2_4_q        <= len2_3_q;
    end
  end

  // stage 5: squares of the vector to normalize
  sba_t              sb5_q;
  logic [SUM_W-1:0]  len2_5_q;
  logic [PROD_W-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q    <= PROD_W'(sb4_q.vx_mag) * PROD_W'(sb4_q.vx_mag);
      sqy_q    <= PROD_W'(sb4_q.vy_mag) * PROD_W'(sb4_q.vy_mag);
      sb5_q    <= sb4_q;
      len2_5_q <= len2_4_q;
    end
  end

  // stage 6: radicand
  sba_t             sb6_q;
  logic [RAD_W-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= (sb5_q.part == PART_INNER) ? RAD_W'(len2_5_q)
                                          : RAD_W'(sqx_q) + RAD_W'(sqy_q);
      sb6_q <= sb5_q;
    end
  end

  // square root with sideband delay line
  logic [ROOT_W-1:0] root;
  sba_t              sba_q [SQRT_STAGES];

  psd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sba_q[0] <= sb6_q;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        sba_q[i] <= sba_q[i-1];
      end
    end
  end

  // dividers: distance and two direction components
  sba_t              sa;
  logic [NUM_W-1:0]  num_x, num_y;
  logic [QUO_W-1:0]  quo_d, quo_x, quo_y;
  sbb_t              sbb_q [DIV_STAGES];

  assign sa    = sba_q[SQRT_STAGES-1];
  assign num_x = NUM_W'({sa.vx_mag, {FRAC_BITS{1'b0}}});
  assign num_y = NUM_W'({sa.vy_mag, {FRAC_BITS{1'b0}}});

  psd_div u_div_dist (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sa.cross_mag),
    .den_i (root),
    .quo_o (quo_d)
  );

  psd_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_x),
    .den_i (root),
    .quo_o (quo_x)
  );

  psd_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_y),
    .den_i (root),
    .quo_o (quo_y)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sbb_q[0].part     <= sa.part;
      sbb_q[0].dir_off  <= sa.dir_off || (root == '0);
      sbb_q[0].zero_all <= sa.zero_all;
      sbb_q[0].vx_neg   <= sa.vx_neg;
      sbb_q[0].vy_neg   <= sa.vy_neg;
      sbb_q[0].sat      <= sa.cross_mag >= {root, {QUO_W{1'b0}}};
      sbb_q[0].root     <= root;
      for (int i = 1; i < DIV_STAGES; i++) begin
        sbb_q[i] <= sbb_q[i-1];
      end
    end
  end

  // output register
  sbb_t                     sb;
  logic [COORD_W-1:0]       dist_d;
  logic signed [DIR_W-1:0]  dirx_d, diry_d;
  logic [DIR_W-1:0]         qx, qy;

  assign sb = sbb_q[DIV_STAGES-1];
  assign qx = {1'b0, quo_x[DIR_W-2:0]};
  assign qy = {1'b0, quo_y[DIR_W-2:0]};

  always_comb begin
    if (sb.zero_all) begin
      dist_d = '0;
      dirx_d = '0;
      diry_d = '0;
    end else begin
      if (sb.part == PART_INNER) begin
        dist_d = sb.sat ? '1 : quo_d[COORD_W-1:0];
      end else begin
        dist_d = (sb.root[ROOT_W-1:COORD_W] != '0) ? '1 : sb.root[COORD_W-1:0];
      end
      if (sb.dir_off) begin
        dirx_d = '0;
        diry_d = '0;
      end else begin
        dirx_d = sb.vx_neg ? DIR_W'(-qx) : qx;
        diry_d = sb.vy_neg ? DIR_W'(-qy) : qy;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      distance_o     <= dist_d;
      dir_x_o        <= dirx_d;
      dir_y_o        <= diry_d;
      nearest_part_o <= sb.part;
    end
  end

  `ASSERT_PROP(a_dir_range, clk_i, rst_ni, !out_valid_o || (dir_x_o <= 18'sd65536 && dir_x_o >= -18'sd65536 && dir_y_o <= 18'sd65536 && dir_y_o >= -18'sd65536))
  `ASSERT_PROP(a_endpoint_dir, clk_i, rst_ni, !(out_valid_o && nearest_part_o != PART_INNER && (dir_x_o != '0 || dir_y_o != '0)) || distance_o != '0)
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(vsq_q) && $stable(vdv_q))

endmodule
